// ===== design/sli_pkg.sv =====
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants for the sorted list block and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

	localparam int unsigned DefCapacity = 16;
	localparam int unsigned ValueW      = 32;
	localparam int unsigned PosW        = 8;
	localparam int unsigned CountOutW   = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	// command broadcast from the controller to every cell
	typedef struct packed {
		logic                     ins;
		logic                     del;
		logic signed [ValueW-1:0] value;
		logic [PosW-1:0]          pos;
	} cell_cmd_t;

endpackage

`default_nettype wire

// ===== design/sli_cell.sv =====
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted list: holds an entry, shifts right on insert,
// shifts left on delete, drives its entry for a read of its position.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_cell
	import sli_pkg::*;
#(
	parameter int unsigned INDEX = 0,
	parameter int unsigned CW    = 5
) (
	input  wire logic                     clk,
	input  wire cell_cmd_t                cmd,
	input  wire logic [CW-1:0]            cnt,
	input  wire logic signed [ValueW-1:0] left_entry,
	input  wire logic                     left_after,
	input  wire logic signed [ValueW-1:0] right_entry,
	output logic signed [ValueW-1:0]      entry,
	output logic                          after,
	output logic [ValueW-1:0]             rd_data
);

	localparam logic [CW-1:0]   Idx  = CW'(INDEX);
	localparam logic [PosW:0]   Pos1 = (PosW+1)'(INDEX + 1);

	logic signed [ValueW-1:0] entry_q;
	logic                     valid;
	logic                     shift_left;

	assign valid      = (Idx < cnt);
	// empty slots count as greater, so the new value lands at the tail
	assign after      = !valid || (entry_q > cmd.value);
	assign shift_left = ({1'b0, cmd.pos} <= Pos1);
	assign entry      = entry_q;
	assign rd_data    = ({1'b0, cmd.pos} == Pos1) ? entry_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.ins && after) begin
			entry_q <= left_after ? left_entry : cmd.value;
		end else if (cmd.del && shift_left) begin
			entry_q <= right_entry;
		end
	end

endmodule

`default_nettype wire

// ===== design/sorted_list_insert_delete.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Sorted list of signed 32-bit values kept in a row of cells; insert,
// delete at position and read at position, one result per transaction.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata fields (low bit up)
//  s_axis   | in  | op[1:0], value[33:2], position[41:34], zero pad to 48
//  m_axis   | out | status[1:0], read_value[33:2], entry_count[41:34], pad
//
//  Every cell compares against the incoming value in parallel, so one
//  transaction is taken per cycle unless stalled; results are registered.
//  The output register takes a new result whenever it is empty or being
//  drained, so a stalled consumer holds s_tready low only while it stalls.
//  Reset clears the count and the output valid; entries need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_delete
	import sli_pkg::*;
#(
	parameter int unsigned CAPACITY = DefCapacity
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // op, value, position
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata    // status, read_value, entry_count
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] Cap = CW'(CAPACITY);

	logic [1:0]               op_in;
	logic signed [ValueW-1:0] value_in;
	logic [PosW-1:0]          pos_in;
	logic                     accept;

	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_nxt;
	status_t                  status;
	cell_cmd_t                cmd;
	logic                     pos_bad;

	logic signed [ValueW-1:0] entries [CAPACITY];
	logic [CAPACITY-1:0]      afters;
	logic [ValueW-1:0]        rd_parts [CAPACITY];
	logic [ValueW-1:0]        rd_all;
	logic [ValueW-1:0]        rd_value;

	logic                     m_tvalid_q;
	status_t                  status_q;
	logic [ValueW-1:0]        rd_value_q;
	logic [CW-1:0]            count_out_q;

	assign op_in    = s_tdata[1:0];
	assign value_in = s_tdata[33:2];
	assign pos_in   = s_tdata[41:34];

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign pos_bad  = (pos_in == '0) || ({1'b0, pos_in} > (PosW+1)'(count_q));

	always_comb begin
		status = ST_OK;
		case (op_in)
			OP_INSERT: begin
				if (count_q == Cap) status = ST_FULL;
			end
			OP_DELETE, OP_READ: begin
				if (count_q == '0) status = ST_EMPTY;
				else if (pos_bad) status = ST_ABSENT;
			end
			default: status = ST_OK;
		endcase
	end

	always_comb begin
		cmd.ins   = accept && (op_in == OP_INSERT) && (status == ST_OK);
		cmd.del   = accept && (op_in == OP_DELETE) && (status == ST_OK);
		cmd.value = value_in;
		cmd.pos   = pos_in;
	end

	always_comb begin
		count_nxt = count_q;
		if (cmd.ins) count_nxt = count_q + CW'(1);
		else if (cmd.del) count_nxt = count_q - CW'(1);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		sli_cell #(
			.INDEX (i),
			.CW    (CW)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.cnt         (count_q),
			.left_entry  ((i == 0) ? entries[0] : entries[(i == 0) ? 0 : i-1]),
			.left_after  ((i == 0) ? 1'b0 : afters[(i == 0) ? 0 : i-1]),
			.right_entry (entries[(i == CAPACITY-1) ? i : i+1]),
			.entry       (entries[i]),
			.after       (afters[i]),
			.rd_data     (rd_parts[i])
		);
	end

	always_comb begin
		rd_all = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_all = rd_all | rd_parts[i];
		end
	end

	assign rd_value = ((op_in == OP_READ) && (status == ST_OK)) ? rd_all : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) count_q <= count_nxt;
			if (s_tready) m_tvalid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q    <= status;
			rd_value_q  <= rd_value;
			count_out_q <= count_nxt;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {6'd0, CountOutW'(count_out_q), rd_value_q, status_q};

endmodule

`default_nettype wire

// ===== design/sli_chk.sv =====
// ----------------------------------------------------------------------------
// sli_chk
// Port-level checks for the sorted list block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sli_chk
	import sli_pkg::*;
#(
	parameter int unsigned CAPACITY = DefCapacity
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [47:0] m_tdata
);

	localparam logic [7:0] Cap = 8'(CAPACITY);

	// hold a stalled result transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[41:34] <= Cap)
		else $error("entry count beyond capacity");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ST_FULL |-> m_tdata[41:34] == Cap)
		else $error("full status with room left");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == ST_EMPTY |-> m_tdata[41:34] == 8'd0)
		else $error("empty status with entries held");

	a_rd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[33:2] == 32'd0)
		else $error("read value on a failed transaction");

endmodule

bind sorted_list_insert_delete sli_chk #(.CAPACITY(CAPACITY)) u_sli_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
